### hdl/servo_sweep_scan_sequencer_unit_assert.svh
// -----------------------------------------------------------------------------
// Servo sweep scan sequencer assertion macros
// Shared concurrent assertion forms; they compile to nothing in synthesis.
// -----------------------------------------------------------------------------
`ifndef SERVO_SWEEP_SCAN_SEQUENCER_UNIT_ASSERT_SVH
`define SERVO_SWEEP_SCAN_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define SSSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo sweep sequencer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SSSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo sweep sequencer: next-cycle check failed");

`else

`define SSSU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SSSU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/sssu_pkg.sv
// -----------------------------------------------------------------------------
// Servo sweep scan sequencer package
// Transfer payload types, register map, mode codes and the target clamp.
// -----------------------------------------------------------------------------
`default_nettype none

package sssu_pkg;

   // Mode codes.
   localparam logic [1:0] MODE_STARTING  = 2'd0;
   localparam logic [1:0] MODE_MOVING    = 2'd1;
   localparam logic [1:0] MODE_MEASURING = 2'd2;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_LOWER_LIMIT     = 3'd0;
   localparam logic [2:0] REG_UPPER_LIMIT     = 3'd1;
   localparam logic [2:0] REG_SPEED_MAGNITUDE = 3'd2;
   localparam logic [2:0] REG_STEP_ANGLE      = 3'd3;
   localparam logic [2:0] REG_DWELL_MS        = 3'd4;

   localparam int unsigned ADDR_WIDTH = 5;

   // Register reset values.
   localparam logic [14:0] SPEED_RESET = 15'd14157;
   localparam logic [14:0] STEP_RESET  = 15'd357;
   localparam logic [15:0] DWELL_RESET = 16'd1000;

   typedef struct packed {
      logic signed [15:0] measured_angle;
      logic [31:0]        time_ms;
      logic               paused;
   } req_type;

   typedef struct packed {
      logic signed [15:0] speed_cmd;
      logic               cmd_valid;
      logic [1:0]         mode;
      logic signed [15:0] target_angle;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] lower_limit;
      logic signed [15:0] upper_limit;
      logic [14:0]        speed_magnitude;
      logic [14:0]        step_angle;
      logic [15:0]        dwell_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic               moving_up;
      logic signed [15:0] target;
      logic [31:0]        arrival_time;
   } state_type;

   // Clamp an 18-bit candidate to the limits; the lower limit is tested first.
   function automatic logic signed [15:0] clamp_angle(
      input logic signed [17:0] value,
      input logic signed [15:0] lower,
      input logic signed [15:0] upper
   );
      logic signed [17:0] lower_ext;
      logic signed [17:0] upper_ext;
      logic signed [15:0] result;
      lower_ext = 18'(lower);
      upper_ext = 18'(upper);
      if (value < lower_ext) begin
         result = lower;
      end else if (value > upper_ext) begin
         result = upper;
      end else begin
         result = value[15:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### hdl/sssu_step.sv
// -----------------------------------------------------------------------------
// Servo sweep scan sequencer step logic
// Computes one tick: next mode, direction, target and arrival time, and the
// result transfer, from the current state, the registers and the input item.
// -----------------------------------------------------------------------------
`default_nettype none

module sssu_step
   import sssu_pkg::*;
(
   input  wire state_type state,
   input  wire cfg_type   cfg,
   input  wire req_type   item,
   output state_type      state_next,
   output rsp_type        result
);

   logic               vel_pos;
   logic               vel_neg;
   logic signed [15:0] speed_pos;
   logic signed [15:0] speed_neg;
   logic signed [15:0] velocity;
   logic signed [17:0] angle_ext;
   logic signed [17:0] step_ext;
   logic signed [17:0] angle_up;
   logic signed [17:0] angle_down;
   logic [31:0]        elapsed;
   logic               dwell_done;
   logic               arrived;
   logic               cmd_valid;
   logic signed [15:0] speed_cmd;

   // Velocity and candidate targets.
   assign speed_pos  = signed'({1'b0, cfg.speed_magnitude});
   assign speed_neg  = -speed_pos;
   assign velocity   = state.moving_up ? speed_pos : speed_neg;
   assign vel_pos    = state.moving_up && (cfg.speed_magnitude != '0);
   assign vel_neg    = !state.moving_up && (cfg.speed_magnitude != '0);
   assign angle_ext  = 18'(item.measured_angle);
   assign step_ext   = signed'({3'b000, cfg.step_angle});
   assign angle_up   = angle_ext + step_ext;
   assign angle_down = angle_ext - step_ext;
   assign elapsed    = item.time_ms - state.arrival_time;
   assign dwell_done = elapsed >= {16'h0000, cfg.dwell_ms};
   assign arrived    = (vel_pos && (item.measured_angle >= state.target)) ||
                       (vel_neg && (item.measured_angle <= state.target));

   // Mode sequencing for one unpaused tick.
   always_comb begin
      state_next = state;
      cmd_valid  = 1'b0;
      speed_cmd  = '0;
      if (!item.paused) begin
         unique case (state.mode)
            MODE_STARTING: begin
               state_next.target = clamp_angle('0, cfg.lower_limit, cfg.upper_limit);
               state_next.mode   = MODE_MOVING;
            end
            MODE_MOVING: begin
               if (arrived) begin
                  state_next.mode         = MODE_MEASURING;
                  state_next.arrival_time = item.time_ms;
               end else begin
                  cmd_valid = 1'b1;
                  speed_cmd = velocity;
               end
            end
            MODE_MEASURING: begin
               if (dwell_done) begin
                  if (vel_pos) begin
                     if (angle_up >= 18'(cfg.upper_limit)) begin
                        state_next.moving_up = !state.moving_up;
                        cmd_valid = 1'b1;
                        speed_cmd = speed_neg;
                        state_next.target =
                           clamp_angle(angle_down, cfg.lower_limit, cfg.upper_limit);
                     end else begin
                        state_next.target =
                           clamp_angle(angle_up, cfg.lower_limit, cfg.upper_limit);
                     end
                  end else begin
                     if (angle_down <= 18'(cfg.lower_limit)) begin
                        state_next.moving_up = !state.moving_up;
                        cmd_valid = 1'b1;
                        speed_cmd = state.moving_up ? speed_neg : speed_pos;
                        state_next.target =
                           clamp_angle(angle_up, cfg.lower_limit, cfg.upper_limit);
                     end else begin
                        state_next.target =
                           clamp_angle(angle_down, cfg.lower_limit, cfg.upper_limit);
                     end
                  end
                  state_next.mode = MODE_MOVING;
               end
            end
            default: begin
               // Unused mode code: the tick does nothing.
            end
         endcase
      end
   end

   // Result shows the state after this tick.
   always_comb begin
      result.speed_cmd    = speed_cmd;
      result.cmd_valid    = cmd_valid;
      result.mode         = state_next.mode;
      result.target_angle = state_next.target;
   end

endmodule

`default_nettype wire

### hdl/servo_sweep_scan_sequencer_unit.sv
// Pipeline: an item transferred on the input channel is held in the input register;
// its result is offered on the result channel from the result register. One item per
// cycle while the result channel does not stall; the step logic sits between the two.
// Reset: synchronous, active high; clears the mode to starting, direction up,
// target and arrival time to zero, the registers to their defaults and both
// pipeline valid flags.
// -----------------------------------------------------------------------------
// Servo sweep scan sequencer
// Steps a servo target between two angle limits, dwelling at each scan point,
// one result transfer per input tick, with an APB-style register port.
// -----------------------------------------------------------------------------
`default_nettype none

`include "servo_sweep_scan_sequencer_unit_assert.svh"

module servo_sweep_scan_sequencer_unit
   import sssu_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // Input channel
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   // Result channel
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output rsp_type               rsp_data,
   // Register port
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire [ADDR_WIDTH-1:0]  paddr,
   input  wire [31:0]            pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   req_type   item_ff;
   logic      item_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      out_free;
   logic      fire;
   logic      csr_write;
   logic [2:0] reg_index;

   // Register writes.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_index = paddr[ADDR_WIDTH-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_LOWER_LIMIT:     cfg_in.lower_limit     = signed'(pwdata[15:0]);
            REG_UPPER_LIMIT:     cfg_in.upper_limit     = signed'(pwdata[15:0]);
            REG_SPEED_MAGNITUDE: cfg_in.speed_magnitude = pwdata[14:0];
            REG_STEP_ANGLE:      cfg_in.step_angle      = pwdata[14:0];
            REG_DWELL_MS:        cfg_in.dwell_ms        = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_limit     <= '0;
         cfg_ff.upper_limit     <= '0;
         cfg_ff.speed_magnitude <= SPEED_RESET;
         cfg_ff.step_angle      <= STEP_RESET;
         cfg_ff.dwell_ms        <= DWELL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_index)
         REG_LOWER_LIMIT:     prdata = 32'(cfg_ff.lower_limit);
         REG_UPPER_LIMIT:     prdata = 32'(cfg_ff.upper_limit);
         REG_SPEED_MAGNITUDE: prdata = {17'h00000, cfg_ff.speed_magnitude};
         REG_STEP_ANGLE:      prdata = {17'h00000, cfg_ff.step_angle};
         REG_DWELL_MS:        prdata = {16'h0000, cfg_ff.dwell_ms};
         default:             prdata = '0;
      endcase
   end

   // Pipeline flow: the input register moves on when the result register is free.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   // Tick computation.
   sssu_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   // Sequencer state advances with each tick handed to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= MODE_STARTING;
         state_ff.moving_up    <= 1'b1;
         state_ff.target       <= '0;
         state_ff.arrival_time <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks.
   `SSSU_ASSERT_NEXT(a_paused_holds_state, clock, reset,
      fire && item_ff.paused, $stable(state_ff))
   `SSSU_ASSERT_NEXT(a_result_matches_state, clock, reset,
      fire, (rsp_ff.mode == state_ff.mode) && (rsp_ff.target_angle == state_ff.target))
   `SSSU_ASSERT_IMPLY(a_idle_cmd_zero, clock, reset,
      rsp_valid_ff && !rsp_ff.cmd_valid, rsp_ff.speed_cmd == '0)
   `SSSU_ASSERT_NEXT(a_stalled_item_kept, clock, reset,
      item_valid_ff && !out_free, item_valid_ff && $stable(item_ff))

endmodule

`default_nettype wire

### dv/sssu_sweep_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Servo sweep sequencer checker
// Watches the register port, the tick channel and the result channel. It keeps
// its own copy of the register settings and the sweep state, predicts one
// result per accepted tick, and compares each result transfer field by field
// with the oldest prediction.
// -----------------------------------------------------------------------------
module sssu_sweep_checker
   import sssu_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   // Tick channel
   input  wire                  req_valid,
   input  wire                  req_ready,
   input  wire req_type         req_data,
   // Result channel
   input  wire                  rsp_valid,
   input  wire                  rsp_ready,
   input  wire rsp_type         rsp_data,
   // Register port
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire [ADDR_WIDTH-1:0] paddr,
   input  wire [31:0]           pwdata,
   input  wire                  pready,
   // Status for the testbench top
   output int                   mismatches,
   output int                   outstanding,
   output int                   results_checked,
   output int                   scan_points,
   output int                   reversals
);

   cfg_type   settings;
   state_type servo;
   rsp_type   predicted_results[$];
   rsp_type   oldest;

   // Bring a wide candidate angle into the window; when the two limits cross, an angle
   // below the lower limit gets the lower limit and any other angle the upper limit.
   function automatic logic signed [15:0] clamp_to_window(input logic signed [17:0] angle);
      logic signed [17:0] low_wide;
      logic signed [17:0] high_wide;
      low_wide  = {{2{settings.lower_limit[15]}}, settings.lower_limit};
      high_wide = {{2{settings.upper_limit[15]}}, settings.upper_limit};
      if (angle < low_wide) begin
         return settings.lower_limit;
      end else if (angle > high_wide) begin
         return settings.upper_limit;
      end
      return angle[15:0];
   endfunction

   // Advance the sweep state by one tick and return the result it produces.
   function automatic rsp_type advance_sweep(input req_type tick);
      rsp_type            result;
      logic signed [15:0] angle;
      logic signed [15:0] target;
      logic signed [16:0] velocity;
      logic signed [16:0] flipped;
      logic signed [17:0] angle_wide;
      logic signed [17:0] step_wide;
      logic signed [17:0] step_up;
      logic signed [17:0] step_down;
      logic signed [17:0] candidate;
      logic [31:0]        elapsed;
      logic               reverse;

      result   = '0;
      angle    = tick.measured_angle;
      target   = servo.target;
      velocity = servo.moving_up ? $signed({2'b00, settings.speed_magnitude})
                                 : -$signed({2'b00, settings.speed_magnitude});
      flipped    = -velocity;
      angle_wide = {{2{angle[15]}}, angle};
      step_wide  = {3'b000, settings.step_angle};
      step_up    = angle_wide + step_wide;
      step_down  = angle_wide - step_wide;

      if (!tick.paused) begin
         case (servo.mode)
            MODE_STARTING: begin
               servo.target = clamp_to_window(18'sd0);
               servo.mode   = MODE_MOVING;
            end
            MODE_MOVING: begin
               // A zero speed is neither direction, so it never arrives.
               if ((velocity > 0 && angle >= target) || (velocity < 0 && angle <= target)) begin
                  servo.mode         = MODE_MEASURING;
                  servo.arrival_time = tick.time_ms;
                  scan_points++;
               end else begin
                  result.cmd_valid = 1'b1;
                  result.speed_cmd = velocity[15:0];
               end
            end
            MODE_MEASURING: begin
               // The elapsed time wraps, so a jump back reads as a long dwell.
               elapsed = tick.time_ms - servo.arrival_time;
               if (elapsed >= {16'h0000, settings.dwell_ms}) begin
                  if (velocity > 0) begin
                     reverse   = step_up >=
                                 $signed({{2{settings.upper_limit[15]}}, settings.upper_limit});
                     candidate = reverse ? step_down : step_up;
                  end else begin
                     reverse   = step_down <=
                                 $signed({{2{settings.lower_limit[15]}}, settings.lower_limit});
                     candidate = reverse ? step_up : step_down;
                  end
                  servo.target = clamp_to_window(candidate);
                  if (reverse) begin
                     servo.moving_up  = !servo.moving_up;
                     result.cmd_valid = 1'b1;
                     result.speed_cmd = flipped[15:0];
                     reversals++;
                  end
                  servo.mode = MODE_MOVING;
               end
            end
            default: begin
            end
         endcase
      end

      result.mode         = servo.mode;
      result.target_angle = servo.target;
      return result;
   endfunction

   task automatic compare_field(input string field, input logic signed [31:0] want_value,
                                input logic signed [31:0] got_value);
      if (got_value !== want_value) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, field, want_value, got_value);
         mismatches++;
      end
   endtask

   // Track register writes, check result transfers, then predict new ticks.
   always @(posedge clock) begin
      if (reset) begin
         settings.lower_limit     = '0;
         settings.upper_limit     = '0;
         settings.speed_magnitude = SPEED_RESET;
         settings.step_angle      = STEP_RESET;
         settings.dwell_ms        = DWELL_RESET;
         servo.mode               = MODE_STARTING;
         servo.moving_up          = 1'b1;
         servo.target             = '0;
         servo.arrival_time       = '0;
         predicted_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_WIDTH-1:2])
               REG_LOWER_LIMIT:     settings.lower_limit     = pwdata[15:0];
               REG_UPPER_LIMIT:     settings.upper_limit     = pwdata[15:0];
               REG_SPEED_MAGNITUDE: settings.speed_magnitude = pwdata[14:0];
               REG_STEP_ANGLE:      settings.step_angle      = pwdata[14:0];
               REG_DWELL_MS:        settings.dwell_ms        = pwdata[15:0];
               default: begin
               end
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: result transfer with no tick outstanding: expected none, actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               oldest = predicted_results.pop_front();
               compare_field("speed_cmd", 32'(oldest.speed_cmd), 32'(rsp_data.speed_cmd));
               compare_field("cmd_valid", 32'(oldest.cmd_valid), 32'(rsp_data.cmd_valid));
               compare_field("mode", 32'(oldest.mode), 32'(rsp_data.mode));
               compare_field("target_angle", 32'(oldest.target_angle),
                             32'(rsp_data.target_angle));
               results_checked++;
            end
         end

         if (req_valid && req_ready) begin
            predicted_results.push_back(advance_sweep(req_data));
         end
      end
      outstanding <= predicted_results.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Servo sweep sequencer testbench
// Drives ticks from a simple servo plant that follows the reported target,
// mixed with noise ticks, pauses and time jumps, under a series of register
// settings and idle patterns. A checker beside the block predicts and compares.
// -----------------------------------------------------------------------------
module tb;
   import sssu_pkg::*;

   localparam int         HOLD_OFF_CYCLES = 80;
   localparam logic [2:0] REG_UNUSED      = 3'd5;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int          mismatches;
   int          outstanding;
   int          results_checked;
   int          scan_points;
   int          reversals;
   int          send_idle_pct    = 0;
   int          recv_stall_pct   = 0;
   bit          hold_request     = 1'b0;
   int          last_target      = 0;
   int          plant_angle      = 0;
   int unsigned plant_time       = 0;
   int unsigned dwell_now        = 1000;
   int          ticks_sent       = 0;
   int          directed_ticks   = 0;
   int          settings_applied = 0;

   servo_sweep_scan_sequencer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   sssu_sweep_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .scan_points     (scan_points),
      .reversals       (reversals)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Generous upper bound on the whole run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // The plant steers toward the most recently reported target.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_target <= int'(rsp_data.target_angle);
      end
   end

   // Register write: setup cycle, access cycle, then an idle cycle.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input int lower, input int upper, input int unsigned speed,
                                 input int unsigned step, input int unsigned dwell);
      csr_write(REG_LOWER_LIMIT, lower);
      csr_write(REG_UPPER_LIMIT, upper);
      csr_write(REG_SPEED_MAGNITUDE, speed);
      csr_write(REG_STEP_ANGLE, step);
      csr_write(REG_DWELL_MS, dwell);
      dwell_now = dwell;
      settings_applied++;
   endtask

   // Offer one tick, with optional idle cycles ahead of it, until transferred.
   task automatic send_tick(input int angle, input int unsigned stamp, input bit pause);
      req_type tick;
      tick.measured_angle = angle[15:0];
      tick.time_ms        = stamp;
      tick.paused         = pause;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   // Stop offering and wait until every predicted result has been checked.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic signed [15:0] noise_angle;
      int                 phase_items;
      int unsigned        time_span;
      bit                 pause;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: start-up, arrival, dwell, step, reversal, extreme angles,
      // time running backward and wrapping, and an unused register address.
      apply_settings(-1000, 1000, 32767, 500, 10);
      csr_write(REG_UNUSED, 32'h1234_5678);
      send_tick(0, 0, 1'b1);
      send_tick(0, 0, 1'b0);
      send_tick(-5, 1, 1'b0);
      send_tick(0, 2, 1'b0);
      send_tick(0, 5, 1'b0);
      send_tick(0, 5, 1'b1);
      send_tick(0, 12, 1'b0);
      send_tick(500, 13, 1'b0);
      send_tick(600, 30, 1'b0);
      send_tick(32767, 31, 1'b0);
      send_tick(-32768, 32, 1'b0);
      send_tick(-32768, 31, 1'b0);
      send_tick(-1000, 32'hFFFF_FFFA, 1'b0);
      drain();

      // Zero speed with crossed limits and the widest step, entered mid-dwell.
      apply_settings(1000, -1000, 0, 32767, 0);
      send_tick(-1000, 4, 1'b0);
      send_tick(0, 5, 1'b0);
      send_tick(0, 6, 1'b1);
      drain();

      // Full-range limits, slowest speed, zero step, longest dwell.
      apply_settings(-32768, 32767, 1, 0, 65535);
      send_tick(-32768, 0, 1'b0);
      send_tick(100, 65534, 1'b0);
      send_tick(32767, 65535, 1'b0);
      send_tick(32767, 65536, 1'b0);
      drain();
      directed_ticks = ticks_sent;

      // Random phases, each under its own settings and idle pattern.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               apply_settings(-8000, 8000, 20000, 1500, 20);
               phase_items = 140; send_idle_pct = 0; recv_stall_pct = 0;
            end
            1: begin
               plant_time = 32'hFFFF_8000;
               apply_settings(-32768, 32767, 32767, 32767, 65535);
               phase_items = 60; send_idle_pct = 58; recv_stall_pct = 0;
            end
            2: begin
               apply_settings(-int'($urandom_range(12000)), int'($urandom_range(12000)),
                              $urandom_range(1, 32767), $urandom_range(1, 3000),
                              $urandom_range(300));
               phase_items = 140; send_idle_pct = 0; recv_stall_pct = 58;
            end
            3: begin
               apply_settings(-3000, 3000, 0, 800, 0);
               phase_items = 40; send_idle_pct = 8; recv_stall_pct = 8;
            end
            4: begin
               apply_settings(-int'($urandom_range(12000)), int'($urandom_range(12000)),
                              $urandom_range(1, 32767), 0, 0);
               phase_items = 100; send_idle_pct = 8; recv_stall_pct = 8;
            end
            5: begin
               apply_settings(2000, -2000, $urandom_range(1, 32767), $urandom_range(3000), 5);
               phase_items = 80; send_idle_pct = 58; recv_stall_pct = 0;
            end
            6: begin
               apply_settings(-int'($urandom_range(12000)), int'($urandom_range(12000)),
                              $urandom_range(1, 32767), $urandom_range(1, 3000),
                              $urandom_range(300));
               phase_items = 150; send_idle_pct = 0; recv_stall_pct = 0;
               hold_request = 1'b1;
            end
            default: begin
               apply_settings(1234, 1234, 32767, 200, 3);
               phase_items = 70; send_idle_pct = 0; recv_stall_pct = 58;
            end
         endcase
         time_span = dwell_now / 3 + 3;

         repeat (phase_items) begin
            if ($urandom_range(99) < 8) begin
               // Noise: arbitrary angle and time stamp.
               noise_angle = 16'($urandom);
               plant_angle = int'(noise_angle);
               plant_time  = $urandom;
               pause       = 1'($urandom_range(1));
            end else begin
               plant_time += $urandom_range(time_span);
               case ($urandom_range(2))
                  0: plant_angle = last_target;
                  1: plant_angle = plant_angle + (last_target - plant_angle) / 2;
                  default: plant_angle = last_target + int'($urandom_range(8)) - 4;
               endcase
               if (plant_angle > 32767) begin
                  plant_angle = 32767;
               end else if (plant_angle < -32768) begin
                  plant_angle = -32768;
               end
               pause = ($urandom_range(99) < 6);
            end
            send_tick(plant_angle, plant_time, pause);
         end
         drain();
      end

      $display("Sent %0d ticks (%0d directed) under %0d register settings, with idle, stall",
               ticks_sent, directed_ticks, settings_applied);
      $display("and %0d-cycle hold-off phases; %0d results checked, %0d dwells, %0d reversals.",
               HOLD_OFF_CYCLES, results_checked, scan_points, reversals);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/sssu_pkg.sv
hdl/sssu_step.sv
hdl/servo_sweep_scan_sequencer_unit.sv
dv/sssu_sweep_checker.sv
dv/tb.sv
